// ----- hdl/c2p_pkg.sv -----
package c2p_pkg;

   // Field widths of the ports.
   localparam int COORD_WIDTH     = 16;
   localparam int MAG_WIDTH       = 16;
   localparam int ANGLE_WIDTH     = 16;
   localparam int QUAD_WIDTH      = 2;

   localparam int CORDIC_STAGES   = 16;
   localparam int ANGLE_FRAC_BITS = 7;

   // The coordinates enter the rotator scaled up by 2^PRESHIFT.
   // Three guard bits cover the sign, the CORDIC gain and the diagonal.
   localparam int PRESHIFT        = 30;
   localparam int CORDIC_WIDTH    = COORD_WIDTH + PRESHIFT + 3;

   // The angle accumulator counts in units of 1e-12 degree.
   localparam int ZACC_WIDTH      = 50;
   localparam longint DEG_UNIT        = 64'sd1000000000000;
   localparam longint ZACC_HALF_TURN  = 180 * DEG_UNIT;
   localparam longint ZACC_FULL_TURN  = 360 * DEG_UNIT;

   // Magnitude: integer square root of x*x + y*y, one root bit per stage.
   localparam int SQ_WIDTH        = 2 * COORD_WIDTH;
   localparam int ROOT_BITS       = COORD_WIDTH;

   localparam int MAIN_STAGES     = (CORDIC_STAGES > ROOT_BITS) ? CORDIC_STAGES : ROOT_BITS;

   // Output angle in units of 2^-ANGLE_FRAC_BITS degree.
   localparam longint ANG_SCALE          = longint'(1) << ANGLE_FRAC_BITS;
   localparam longint ANG_QUARTER        = 90 * ANG_SCALE;
   localparam longint ANG_HALF           = 180 * ANG_SCALE;
   localparam longint ANG_THREE_QUARTERS = 270 * ANG_SCALE;
   localparam longint ANG_FULL_TURN      = 360 * ANG_SCALE;
   localparam int ANG_BITS               = $clog2(ANG_FULL_TURN + 1);

   // floor((z * 2^ANGLE_FRAC_BITS + 1e12/2) / 1e12) equals
   // floor((z + ANG_ROUND) / ANG_DIVISOR), with a numerator below 2^NUM_WIDTH.
   localparam longint ANG_DIVISOR = DEG_UNIT / ANG_SCALE;
   localparam longint ANG_ROUND   = ANG_DIVISOR / 2;
   localparam int     NUM_WIDTH   = ZACC_WIDTH - 1;

   // The quotient is first estimated from the top 32 numerator bits times a
   // reciprocal. The estimate is never high and at most one low.
   localparam int     EST_DROP    = NUM_WIDTH - 32;
   localparam int     RECIP_SHIFT = 32;
   localparam longint ANG_RECIP   = (longint'(1) << (EST_DROP + RECIP_SHIFT)) / ANG_DIVISOR;

   localparam logic [QUAD_WIDTH-1:0] QUAD_FIRST  = 2'd0;
   localparam logic [QUAD_WIDTH-1:0] QUAD_SECOND = 2'd1;
   localparam logic [QUAD_WIDTH-1:0] QUAD_THIRD  = 2'd2;
   localparam logic [QUAD_WIDTH-1:0] QUAD_FOURTH = 2'd3;

   // atan(2^-i) in units of 1e-12 degree, rounded to nearest.
   localparam longint ATAN_TABLE [32] = '{
      64'sd45000000000000, 64'sd26565051177078, 64'sd14036243467926, 64'sd7125016348902,
      64'sd3576334374997,  64'sd1789910608246,  64'sd895173710211,   64'sd447614170861,
      64'sd223810500369,   64'sd111905677066,   64'sd55952891894,    64'sd27976452617,
      64'sd13988227142,    64'sd6994113675,     64'sd3497056851,     64'sd1748528427,
      64'sd874264214,      64'sd437132107,      64'sd218566053,      64'sd109283027,
      64'sd54641513,       64'sd27320757,       64'sd13660378,       64'sd6830189,
      64'sd3415095,        64'sd1707547,        64'sd853774,         64'sd426887,
      64'sd213443,         64'sd106722,         64'sd53361,          64'sd26680
   };

endpackage

// ----- hdl/cartesian_to_polar.sv -----
// Cartesian to polar converter.
// An item is a signed point (req_x_coord, req_y_coord). It is taken at a rising edge where
// start is high and busy is low. busy is high only during reset and the cycle after it;
// otherwise the pipeline takes one item in every cycle.
// Each item gives one result: rsp_magnitude (rounded length), rsp_angle_deg (counterclockwise
// from +x in 1/128 degree, 0 up to below 360) and rsp_quadrant. The result stands on the rsp_ ports
// for exactly one cycle, marked by rsp_valid, and is taken at the edge that ends that cycle.
// The result comes from the vectoring CORDIC (one rotation per stage, run next to a
// one-bit-per-stage square root) and from the four-stage conversion of the angle into
// output units (offset, reciprocal estimate, back multiply, one correction).
// Throughput is one item per cycle. Results leave in the order the items came in.
// The receiver cannot stall the block; nothing is held back.
// A synchronous reset clears every valid bit, so items in flight are dropped and no strobe
// follows until new items are taken.
module cartesian_to_polar
   import c2p_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_x_coord,
   input  logic signed [COORD_WIDTH-1:0] req_y_coord,
   output logic                          rsp_valid,
   output logic [MAG_WIDTH-1:0]          rsp_magnitude,
   output logic [ANGLE_WIDTH-1:0]        rsp_angle_deg,
   output logic [QUAD_WIDTH-1:0]         rsp_quadrant
);

   logic busy_ff;
   logic accept;

   // Input stage: absolute values and squares.
   logic [COORD_WIDTH-1:0]          abs_x;
   logic [COORD_WIDTH-1:0]          abs_y;
   logic [SQ_WIDTH-1:0]             sq_x_in;
   logic [SQ_WIDTH-1:0]             sq_y_in;
   logic                            p_valid_ff;
   logic signed [COORD_WIDTH-1:0]   p_x_ff;
   logic signed [COORD_WIDTH-1:0]   p_y_ff;
   logic [SQ_WIDTH-1:0]             p_sq_x_ff;
   logic [SQ_WIDTH-1:0]             p_sq_y_ff;

   // Rotator and square root stages; index 0 is loaded by the setup stage.
   logic signed [CORDIC_WIDTH-1:0]  cx_init;
   logic signed [CORDIC_WIDTH-1:0]  cy_init;
   logic signed [ZACC_WIDTH-1:0]    z_init;
   logic                            m_valid_ff [MAIN_STAGES+1];
   logic signed [CORDIC_WIDTH-1:0]  cx_ff      [MAIN_STAGES+1];
   logic signed [CORDIC_WIDTH-1:0]  cy_ff      [MAIN_STAGES+1];
   logic signed [ZACC_WIDTH-1:0]    z_ff       [MAIN_STAGES+1];
   logic [SQ_WIDTH-1:0]             sq_rem_ff  [MAIN_STAGES+1];
   logic [SQ_WIDTH-1:0]             sq_root_ff [MAIN_STAGES+1];
   logic                            m_org_ff   [MAIN_STAGES+1];

   // Wrap stage.
   logic signed [ZACC_WIDTH-1:0]    z_wrap_in;
   logic                            round_up;
   logic [ROOT_BITS:0]              mag_in;
   logic                            w_valid_ff;
   logic signed [ZACC_WIDTH-1:0]    w_z_ff;
   logic [ROOT_BITS:0]              w_mag_ff;
   logic                            w_org_ff;

   // Degree conversion stages.
   logic                            n_valid_ff;
   logic [NUM_WIDTH-1:0]            n_num_ff;
   logic [ROOT_BITS:0]              n_mag_ff;
   logic                            n_org_ff;
   logic [NUM_WIDTH-1:0]            e_prod_in;
   logic                            e_valid_ff;
   logic [NUM_WIDTH-1:0]            e_num_ff;
   logic [NUM_WIDTH-1:0]            e_prod_ff;
   logic [ROOT_BITS:0]              e_mag_ff;
   logic                            e_org_ff;
   logic [ANG_BITS-1:0]             q_est_in;
   logic [NUM_WIDTH-1:0]            q_back_in;
   logic                            q_valid_ff;
   logic [NUM_WIDTH-1:0]            q_num_ff;
   logic [ANG_BITS-1:0]             q_est_ff;
   logic [NUM_WIDTH-1:0]            q_back_ff;
   logic [ROOT_BITS:0]              q_mag_ff;
   logic                            q_org_ff;
   logic [NUM_WIDTH-1:0]            corr_rem;
   logic [ANG_BITS-1:0]             c_quot_in;
   logic                            c_valid_ff;
   logic [ANG_BITS-1:0]             c_quot_ff;
   logic [ROOT_BITS:0]              c_mag_ff;
   logic                            c_org_ff;

   // Output stage.
   logic [ANG_BITS-1:0]             ang_in;
   logic [QUAD_WIDTH-1:0]           quad_in;
   logic                            f_valid_ff;
   logic [MAG_WIDTH-1:0]            f_mag_ff;
   logic [ANGLE_WIDTH-1:0]          f_angle_ff;
   logic [QUAD_WIDTH-1:0]           f_quad_ff;

   assign busy   = busy_ff;
   assign accept = start & ~busy_ff;

   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   // ---------------------------------------------------------------- input stage
   always_comb begin
      abs_x   = req_x_coord[COORD_WIDTH-1] ? COORD_WIDTH'(-req_x_coord) : COORD_WIDTH'(req_x_coord);
      abs_y   = req_y_coord[COORD_WIDTH-1] ? COORD_WIDTH'(-req_y_coord) : COORD_WIDTH'(req_y_coord);
      sq_x_in = abs_x * abs_x;
      sq_y_in = abs_y * abs_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= accept;
      end
      p_x_ff    <= req_x_coord;
      p_y_ff    <= req_y_coord;
      p_sq_x_ff <= sq_x_in;
      p_sq_y_ff <= sq_y_in;
   end

   // ---------------------------------------------------------------- setup stage
   // A point in the left half-plane is turned by 180 degrees before the rotations.
   always_comb begin
      cx_init = CORDIC_WIDTH'(p_x_ff) <<< PRESHIFT;
      cy_init = CORDIC_WIDTH'(p_y_ff) <<< PRESHIFT;
      z_init  = '0;
      if (p_x_ff[COORD_WIDTH-1]) begin
         cx_init = -cx_init;
         cy_init = -cy_init;
         z_init  = ZACC_WIDTH'(ZACC_HALF_TURN);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff[0] <= 1'b0;
      end else begin
         m_valid_ff[0] <= p_valid_ff;
      end
      cx_ff[0]      <= cx_init;
      cy_ff[0]      <= cy_init;
      z_ff[0]       <= z_init;
      sq_rem_ff[0]  <= p_sq_x_ff + p_sq_y_ff;
      sq_root_ff[0] <= '0;
      m_org_ff[0]   <= (p_x_ff == '0) && (p_y_ff == '0);
   end

   // ---------------------------------------------------------------- main stages
   for (genvar s = 0; s < MAIN_STAGES; s++) begin : g_main
      logic signed [CORDIC_WIDTH-1:0] cx_in;
      logic signed [CORDIC_WIDTH-1:0] cy_in;
      logic signed [ZACC_WIDTH-1:0]   z_in;
      logic [SQ_WIDTH-1:0]            rem_in;
      logic [SQ_WIDTH-1:0]            root_in;

      if (s < CORDIC_STAGES) begin : g_rot
         localparam logic signed [ZACC_WIDTH-1:0] ATAN_STEP = ZACC_WIDTH'(ATAN_TABLE[s % 32]);

         // Each rotation drives y toward zero; the accumulator keeps the angle turned.
         always_comb begin
            if (cy_ff[s][CORDIC_WIDTH-1]) begin
               cx_in = cx_ff[s] - (cy_ff[s] >>> s);
               cy_in = cy_ff[s] + (cx_ff[s] >>> s);
               z_in  = z_ff[s] - ATAN_STEP;
            end else begin
               cx_in = cx_ff[s] + (cy_ff[s] >>> s);
               cy_in = cy_ff[s] - (cx_ff[s] >>> s);
               z_in  = z_ff[s] + ATAN_STEP;
            end
         end
      end else begin : g_rot_pass
         always_comb begin
            cx_in = cx_ff[s];
            cy_in = cy_ff[s];
            z_in  = z_ff[s];
         end
      end

      if (s < ROOT_BITS) begin : g_root
         localparam logic [SQ_WIDTH-1:0] ROOT_BIT = SQ_WIDTH'(64'd1 << (2 * (ROOT_BITS - 1 - s)));
         logic [SQ_WIDTH:0] trial;

         always_comb begin
            trial = {1'b0, sq_root_ff[s]} + {1'b0, ROOT_BIT};
            if ({1'b0, sq_rem_ff[s]} >= trial) begin
               rem_in  = SQ_WIDTH'({1'b0, sq_rem_ff[s]} - trial);
               root_in = (sq_root_ff[s] >> 1) + ROOT_BIT;
            end else begin
               rem_in  = sq_rem_ff[s];
               root_in = sq_root_ff[s] >> 1;
            end
         end
      end else begin : g_root_pass
         always_comb begin
            rem_in  = sq_rem_ff[s];
            root_in = sq_root_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            m_valid_ff[s+1] <= 1'b0;
         end else begin
            m_valid_ff[s+1] <= m_valid_ff[s];
         end
         cx_ff[s+1]      <= cx_in;
         cy_ff[s+1]      <= cy_in;
         z_ff[s+1]       <= z_in;
         sq_rem_ff[s+1]  <= rem_in;
         sq_root_ff[s+1] <= root_in;
         m_org_ff[s+1]   <= m_org_ff[s];
      end
   end

   // ---------------------------------------------------------------- wrap stage
   // The angle wraps into one turn. The root rounds up when the remainder exceeds it; an exact half cannot occur.
   always_comb begin
      priority if (z_ff[MAIN_STAGES][ZACC_WIDTH-1]) begin
         z_wrap_in = z_ff[MAIN_STAGES] + ZACC_WIDTH'(ZACC_FULL_TURN);
      end else if (z_ff[MAIN_STAGES] >= ZACC_WIDTH'(ZACC_FULL_TURN)) begin
         z_wrap_in = z_ff[MAIN_STAGES] - ZACC_WIDTH'(ZACC_FULL_TURN);
      end else begin
         z_wrap_in = z_ff[MAIN_STAGES];
      end
      round_up = sq_rem_ff[MAIN_STAGES] > sq_root_ff[MAIN_STAGES];
      mag_in   = (ROOT_BITS + 1)'(sq_root_ff[MAIN_STAGES]) + {{ROOT_BITS{1'b0}}, round_up};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_valid_ff <= 1'b0;
      end else begin
         w_valid_ff <= m_valid_ff[MAIN_STAGES];
      end
      w_z_ff   <= z_wrap_in;
      w_mag_ff <= mag_in;
      w_org_ff <= m_org_ff[MAIN_STAGES];
   end

   // ---------------------------------------------------------------- numerator stage
   // angle = floor((z * 2^ANGLE_FRAC_BITS + 1e12/2) / 1e12)
   //       = floor((z + ANG_ROUND) / ANG_DIVISOR); the wrapped z is never negative.
   always_ff @(posedge clock) begin
      if (reset) begin
         n_valid_ff <= 1'b0;
      end else begin
         n_valid_ff <= w_valid_ff;
      end
      n_num_ff <= NUM_WIDTH'($unsigned(w_z_ff)) + NUM_WIDTH'(ANG_ROUND);
      n_mag_ff <= w_mag_ff;
      n_org_ff <= w_org_ff;
   end

   // ---------------------------------------------------------------- estimate stage
   always_comb begin
      e_prod_in = NUM_WIDTH'(n_num_ff[NUM_WIDTH-1:EST_DROP]) * NUM_WIDTH'(ANG_RECIP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= n_valid_ff;
      end
      e_num_ff  <= n_num_ff;
      e_prod_ff <= e_prod_in;
      e_mag_ff  <= n_mag_ff;
      e_org_ff  <= n_org_ff;
   end

   // ---------------------------------------------------------------- back multiply stage
   always_comb begin
      q_est_in  = e_prod_ff[RECIP_SHIFT +: ANG_BITS];
      q_back_in = NUM_WIDTH'(q_est_in) * NUM_WIDTH'(ANG_DIVISOR);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 1'b0;
      end else begin
         q_valid_ff <= e_valid_ff;
      end
      q_num_ff  <= e_num_ff;
      q_est_ff  <= q_est_in;
      q_back_ff <= q_back_in;
      q_mag_ff  <= e_mag_ff;
      q_org_ff  <= e_org_ff;
   end

   // ---------------------------------------------------------------- correction stage
   // The estimate is at most one low, so one compare of the remainder settles it.
   always_comb begin
      corr_rem  = q_num_ff - q_back_ff;
      c_quot_in = q_est_ff;
      if (corr_rem >= NUM_WIDTH'(ANG_DIVISOR)) begin
         c_quot_in = q_est_ff + ANG_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= q_valid_ff;
      end
      c_quot_ff <= c_quot_in;
      c_mag_ff  <= q_mag_ff;
      c_org_ff  <= q_org_ff;
   end

   // ---------------------------------------------------------------- output stage
   // A full turn after rounding wraps to zero, and the origin reports zero; the quadrant follows from the angle.
   always_comb begin
      if (c_org_ff || (c_quot_ff >= ANG_BITS'(ANG_FULL_TURN))) begin
         ang_in = '0;
      end else begin
         ang_in = c_quot_ff;
      end
      priority if (ang_in > ANG_BITS'(ANG_THREE_QUARTERS)) begin
         quad_in = QUAD_FOURTH;
      end else if (ang_in > ANG_BITS'(ANG_HALF)) begin
         quad_in = QUAD_THIRD;
      end else if (ang_in > ANG_BITS'(ANG_QUARTER)) begin
         quad_in = QUAD_SECOND;
      end else begin
         quad_in = QUAD_FIRST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= c_valid_ff;
      end
      f_mag_ff   <= MAG_WIDTH'(c_mag_ff);
      f_angle_ff <= ANGLE_WIDTH'(ang_in);
      f_quad_ff  <= quad_in;
   end

   assign rsp_valid     = f_valid_ff;
   assign rsp_magnitude = f_mag_ff;
   assign rsp_angle_deg = f_angle_ff;
   assign rsp_quadrant  = f_quad_ff;

endmodule
